### rtl/tbalm_pkg.sv
// Package: shared types and constants of the three-band audio level meter.
package tbalm_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int FILT_W      = SAMPLE_BITS + 2;
	localparam int BAND_W      = FILT_W + 1;
	localparam int SUM_W       = 60;
	localparam int CNT_W       = 17;
	localparam int ENV_W       = 31;
	localparam int ROOT_W      = SUM_W / 2;
	localparam int LEVEL_W     = 16;
	localparam int COEF_W      = 16;
	localparam int FACT_W      = 17;
	localparam int GAIN_W      = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 17;
	localparam int Q_DEPTH     = 2;
	localparam int OUT_SHIFT   = SAMPLE_BITS - 9;
	localparam int DIV_STEPS   = SUM_W;
	localparam int SQRT_STEPS  = ROOT_W;
	localparam int N_BANDS     = 4;
	localparam int N_LEVELS    = 5;

	localparam logic [SUM_W-1:0]   SUM_CAP   = {SUM_W{1'b1}};
	localparam logic [FACT_W-1:0]  FACT_ONE  = FACT_W'(65536);
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LOW_COEF = 3'd0,
		CFG_MID_COEF = 3'd1,
		CFG_ATTACK   = 3'd2,
		CFG_RELEASE  = 3'd3,
		CFG_GAIN     = 3'd4
	} cfg_index_t;

	typedef struct packed {
		logic [COEF_W-1:0] low_coef;
		logic [COEF_W-1:0] mid_coef;
		logic [FACT_W-1:0] atk_fact;
		logic [FACT_W-1:0] rel_fact;
		logic [GAIN_W-1:0] gain;
	} cfg_regs_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          last_of_block;
		logic                          muted;
	} in_beat_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [LEVEL_W-1:0] peak;
		logic [LEVEL_W-1:0] low_level;
		logic [LEVEL_W-1:0] mid_level;
		logic [LEVEL_W-1:0] high_level;
	} out_beat_t;

	typedef struct packed {
		logic [N_BANDS-1:0][SUM_W-1:0] sums;
		logic [SAMPLE_BITS-1:0]        peak;
		logic [CNT_W-1:0]              count;
		logic                          muted;
	} block_rec_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DIV,
		BK_SQRT,
		BK_ENV_MUL,
		BK_ENV_ADD,
		BK_SCL_MUL,
		BK_SCL_SAT,
		BK_EMIT
	} back_state_t;

endpackage

### rtl/tbalm_front.sv
// Front end: per-sample band split, squaring and block accumulation.
module tbalm_front #(
	parameter int MAX_BLOCK = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  tbalm_pkg::in_beat_t  in_data,
	input  tbalm_pkg::cfg_regs_t cfg,
	input  logic                 pop,
	output logic                 push_valid,
	output tbalm_pkg::block_rec_t push_rec
);

	localparam int CW = $clog2(MAX_BLOCK + 1);
	localparam int RW = $clog2(tbalm_pkg::Q_DEPTH + 1);
	localparam int FW = tbalm_pkg::FILT_W;
	localparam int BW = tbalm_pkg::BAND_W;
	localparam int SB = tbalm_pkg::SAMPLE_BITS;
	localparam int SW = tbalm_pkg::SUM_W;
	localparam int NB = tbalm_pkg::N_BANDS;
	localparam int PW = FW + tbalm_pkg::COEF_W + 2;

	logic accept;
	logic [RW-1:0] reserved_q;

	logic signed [FW-1:0] low_q, mid_q, saved_low_q, saved_mid_q;
	logic open_q;
	logic signed [FW-1:0] s_ext, new_low, new_mid;
	logic signed [FW:0] diff_low, diff_mid;
	logic signed [PW-1:0] prod_low, prod_mid;

	logic signed [BW-1:0] band_s1 [NB];
	logic v_s1, last_s1, muted_s1;

	logic [SW-1:0] sq_s2 [NB];
	logic [SB-1:0] mag_s2;
	logic v_s2, last_s2, muted_s2;

	logic [NB-1:0][SW-1:0] sums_q, sums_n;
	logic [SB-1:0] peak_q, peak_n;
	logic [CW-1:0] cnt_q, cnt_n;

	assign accept   = in_valid && !in_stall;
	// Every block in the pipe or the queue holds a slot, so a push never overflows.
	assign in_stall = (reserved_q == RW'(tbalm_pkg::Q_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserved_q <= '0;
		end else begin
			reserved_q <= reserved_q + RW'(accept && in_data.last_of_block) - RW'(pop);
		end
	end

	assign s_ext    = FW'(in_data.sample);
	assign diff_low = (FW+1)'(s_ext) - (FW+1)'(low_q);
	assign diff_mid = (FW+1)'(s_ext) - (FW+1)'(mid_q);
	assign prod_low = diff_low * $signed({1'b0, cfg.low_coef});
	assign prod_mid = diff_mid * $signed({1'b0, cfg.mid_coef});
	assign new_low  = low_q + FW'(prod_low >>> tbalm_pkg::COEF_W);
	assign new_mid  = mid_q + FW'(prod_mid >>> tbalm_pkg::COEF_W);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q       <= '0;
			mid_q       <= '0;
			saved_low_q <= '0;
			saved_mid_q <= '0;
			open_q      <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			sums_q      <= '0;
			peak_q      <= '0;
			cnt_q       <= '0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			if (accept) begin
				if (!open_q) begin
					saved_low_q <= low_q;
					saved_mid_q <= mid_q;
				end
				open_q <= !in_data.last_of_block;
				if (in_data.last_of_block && in_data.muted) begin
					// A muted block leaves the filters as they were before it.
					low_q <= open_q ? saved_low_q : low_q;
					mid_q <= open_q ? saved_mid_q : mid_q;
				end else begin
					low_q <= new_low;
					mid_q <= new_mid;
				end
			end
			if (v_s2) begin
				if (last_s2) begin
					sums_q <= '0;
					peak_q <= '0;
					cnt_q  <= '0;
				end else begin
					sums_q <= sums_n;
					peak_q <= peak_n;
					cnt_q  <= cnt_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			band_s1[0] <= BW'(s_ext);
			band_s1[1] <= BW'(new_low);
			band_s1[2] <= BW'(new_mid) - BW'(new_low);
			band_s1[3] <= BW'(s_ext) - BW'(new_mid);
			last_s1    <= in_data.last_of_block;
			muted_s1   <= in_data.muted;
		end
	end

	always_ff @(posedge clk) begin
		logic [BW-1:0] mag;
		logic [31:0]   m32;
		if (v_s1) begin
			for (int i = 0; i < NB; i++) begin
				mag = band_s1[i][BW-1] ? BW'(-band_s1[i]) : BW'(band_s1[i]);
				m32 = 32'(mag);
				sq_s2[i] <= (|m32[31:30]) ? tbalm_pkg::SUM_CAP : SW'(m32[29:0] * m32[29:0]);
			end
			mag      = band_s1[0][BW-1] ? BW'(-band_s1[0]) : BW'(band_s1[0]);
			mag_s2   <= SB'(mag);
			last_s2  <= last_s1;
			muted_s2 <= muted_s1;
		end
	end

	always_comb begin
		logic [SW:0] sum;
		for (int i = 0; i < NB; i++) begin
			sum       = {1'b0, sums_q[i]} + {1'b0, sq_s2[i]};
			sums_n[i] = sum[SW] ? tbalm_pkg::SUM_CAP : sum[SW-1:0];
		end
		peak_n = (mag_s2 > peak_q) ? mag_s2 : peak_q;
		cnt_n  = (cnt_q == CW'(MAX_BLOCK)) ? cnt_q : cnt_q + CW'(1);
	end

	assign push_valid     = v_s2 && last_s2;
	assign push_rec.sums  = sums_n;
	assign push_rec.peak  = peak_n;
	assign push_rec.count = tbalm_pkg::CNT_W'(cnt_n);
	assign push_rec.muted = muted_s2;

endmodule

### rtl/tbalm_queue.sv
// Short queue of finished block records between the front and back ends.
module tbalm_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push_valid,
	input  tbalm_pkg::block_rec_t push_rec,
	input  logic                  pop,
	output logic                  head_valid,
	output tbalm_pkg::block_rec_t head_rec
);

	localparam int AW = $clog2(tbalm_pkg::Q_DEPTH);
	localparam int CW = $clog2(tbalm_pkg::Q_DEPTH + 1);

	tbalm_pkg::block_rec_t mem [tbalm_pkg::Q_DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push_valid) begin
			mem[wr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push_valid) begin
				wr_q <= (wr_q == AW'(tbalm_pkg::Q_DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(tbalm_pkg::Q_DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			count_q <= count_q + CW'(push_valid) - CW'(pop);
		end
	end

	assign head_valid = (count_q != '0);
	assign head_rec   = mem[rd_q];

endmodule

### rtl/tbalm_back.sv
// Back end: mean square divide, square root, envelopes, gain and saturation.
module tbalm_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tbalm_pkg::cfg_regs_t  cfg,
	input  logic                  head_valid,
	input  tbalm_pkg::block_rec_t head_rec,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output tbalm_pkg::out_beat_t  out_data
);

	localparam int SW  = tbalm_pkg::SUM_W;
	localparam int CNW = tbalm_pkg::CNT_W;
	localparam int EW  = tbalm_pkg::ENV_W;
	localparam int RTW = tbalm_pkg::ROOT_W;
	localparam int LW  = tbalm_pkg::LEVEL_W;
	localparam int MW  = EW + tbalm_pkg::GAIN_W;
	localparam int DPW = EW + 1 + tbalm_pkg::FACT_W + 1;

	tbalm_pkg::back_state_t state_q, state_n;
	tbalm_pkg::block_rec_t  rec_q;
	tbalm_pkg::out_beat_t   res_q, out_q;
	logic out_valid_q;
	logic [1:0] band_q;
	logic [2:0] lvl_q;
	logic [5:0] step_q;
	logic [CNW-1:0] rem_q;
	logic [SW-1:0]  quo_q;
	logic [RTW-1:0] root_q;
	logic [RTW+1:0] srem_q;
	logic [EW-1:0]  env_q [tbalm_pkg::N_BANDS];
	logic signed [DPW-1:0] prod_q;
	logic [MW-1:0]  scl_q;
	logic out_free, div_done, sqrt_done;

	logic [CNW:0]   div_trial;
	logic [RTW+3:0] sq_next, sq_trial;
	logic signed [EW:0] env_diff;
	logic [tbalm_pkg::FACT_W-1:0] fact;
	logic [EW-1:0] scl_val;
	logic [MW-1:0] scl_sh;
	logic [LW-1:0] scl_sat;

	assign out_free  = !out_valid_q || !out_stall;
	assign div_done  = (step_q == 6'(tbalm_pkg::DIV_STEPS - 1));
	assign sqrt_done = (step_q == 6'(tbalm_pkg::SQRT_STEPS - 1));

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			tbalm_pkg::BK_IDLE: begin
				if (head_valid) begin
					state_n = head_rec.muted ? tbalm_pkg::BK_EMIT : tbalm_pkg::BK_DIV;
				end
			end
			tbalm_pkg::BK_DIV:     if (div_done) state_n = tbalm_pkg::BK_SQRT;
			tbalm_pkg::BK_SQRT:    if (sqrt_done) state_n = tbalm_pkg::BK_ENV_MUL;
			tbalm_pkg::BK_ENV_MUL: state_n = tbalm_pkg::BK_ENV_ADD;
			tbalm_pkg::BK_ENV_ADD: begin
				state_n = (band_q == 2'd3) ? tbalm_pkg::BK_SCL_MUL : tbalm_pkg::BK_DIV;
			end
			tbalm_pkg::BK_SCL_MUL: state_n = tbalm_pkg::BK_SCL_SAT;
			tbalm_pkg::BK_SCL_SAT: begin
				state_n = (lvl_q == 3'(tbalm_pkg::N_LEVELS - 1)) ? tbalm_pkg::BK_EMIT
					: tbalm_pkg::BK_SCL_MUL;
			end
			tbalm_pkg::BK_EMIT:    if (out_free) state_n = tbalm_pkg::BK_IDLE;
			default:               state_n = tbalm_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		pop = 1'b0;
		unique case (state_q)
			tbalm_pkg::BK_IDLE: pop = head_valid;
			default:            pop = 1'b0;
		endcase
	end

	// Datapath helpers for the shared divide and square-root steps.
	assign div_trial = {rem_q, quo_q[SW-1]};
	assign sq_next   = {srem_q, quo_q[SW-1:SW-2]};
	assign sq_trial  = (RTW+4)'({root_q, 2'b01});
	assign env_diff  = $signed({2'b00, root_q}) - $signed({1'b0, env_q[band_q]});

	always_comb begin
		fact = ($signed({2'b00, root_q}) > $signed({1'b0, env_q[band_q]})) ? cfg.atk_fact
			: cfg.rel_fact;
		if (fact > tbalm_pkg::FACT_ONE) begin
			fact = tbalm_pkg::FACT_ONE;
		end
		case (lvl_q)
			3'd0:    scl_val = env_q[0];
			3'd1:    scl_val = EW'(rec_q.peak);
			3'd2:    scl_val = env_q[1];
			3'd3:    scl_val = env_q[2];
			default: scl_val = env_q[3];
		endcase
		scl_sh  = scl_q >> tbalm_pkg::OUT_SHIFT;
		scl_sat = (|scl_sh[MW-1:LW]) ? tbalm_pkg::LEVEL_MAX : scl_sh[LW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tbalm_pkg::BK_IDLE;
			out_valid_q <= 1'b0;
			for (int i = 0; i < tbalm_pkg::N_BANDS; i++) begin
				env_q[i] <= '0;
			end
		end else begin
			state_q <= state_n;
			if (state_q == tbalm_pkg::BK_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == tbalm_pkg::BK_ENV_ADD) begin
				env_q[band_q] <= env_q[band_q] + EW'(prod_q >>> tbalm_pkg::COEF_W);
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			tbalm_pkg::BK_IDLE: begin
				rec_q  <= head_rec;
				res_q  <= '0;
				band_q <= '0;
				lvl_q  <= '0;
				step_q <= '0;
				rem_q  <= '0;
				srem_q <= '0;
				root_q <= '0;
				quo_q  <= head_rec.sums[0];
			end
			tbalm_pkg::BK_DIV: begin
				if (div_trial >= {1'b0, rec_q.count}) begin
					rem_q <= CNW'(div_trial - {1'b0, rec_q.count});
					quo_q <= {quo_q[SW-2:0], 1'b1};
				end else begin
					rem_q <= CNW'(div_trial);
					quo_q <= {quo_q[SW-2:0], 1'b0};
				end
				step_q <= div_done ? '0 : step_q + 6'd1;
			end
			tbalm_pkg::BK_SQRT: begin
				if (sq_next >= sq_trial) begin
					srem_q <= (RTW+2)'(sq_next - sq_trial);
					root_q <= {root_q[RTW-2:0], 1'b1};
				end else begin
					srem_q <= (RTW+2)'(sq_next);
					root_q <= {root_q[RTW-2:0], 1'b0};
				end
				quo_q  <= {quo_q[SW-3:0], 2'b00};
				step_q <= sqrt_done ? '0 : step_q + 6'd1;
			end
			tbalm_pkg::BK_ENV_MUL: begin
				prod_q <= env_diff * $signed({1'b0, fact});
			end
			tbalm_pkg::BK_ENV_ADD: begin
				band_q <= band_q + 2'd1;
				quo_q  <= rec_q.sums[band_q + 2'd1];
				rem_q  <= '0;
				srem_q <= '0;
				root_q <= '0;
			end
			tbalm_pkg::BK_SCL_MUL: begin
				scl_q <= scl_val * cfg.gain;
			end
			tbalm_pkg::BK_SCL_SAT: begin
				case (lvl_q)
					3'd0:    res_q.level      <= scl_sat;
					3'd1:    res_q.peak       <= scl_sat;
					3'd2:    res_q.low_level  <= scl_sat;
					3'd3:    res_q.mid_level  <= scl_sat;
					default: res_q.high_level <= scl_sat;
				endcase
				lvl_q <= lvl_q + 3'd1;
			end
			tbalm_pkg::BK_EMIT: begin
				if (out_free) begin
					out_q <= res_q;
				end
			end
			default: begin
				band_q <= '0;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### rtl/three_band_audio_level_meter.sv
// Top level of the three-band audio level meter.
//
// Samples arrive as beats on the input channel (in_valid, in_stall, in_data) and
// one result beat per block leaves on the output channel (out_valid, out_stall,
// out_data). A beat moves at a clock edge with valid high and stall low.
// The input takes one sample beat per cycle while in_stall is low. The front end
// filters, squares and accumulates each sample in a three-stage pipeline; the last
// beat of a block hands its record to a two-entry queue. While the queue and the
// pipe hold two blocks, in_stall rises until the back end takes one.
// The back end runs a bit-serial divider and a square-root unit once per band,
// plus the envelope multiply and add, four bands in all, then gain and
// saturation for each of the five result levels. A muted block skips that work
// and gives zeros.
// A result waits in the output register while out_stall is high; the back end
// and front end keep working behind it.
// Reset clears filters, sums, envelopes and handshake state and loads the
// register defaults. Registers are written through cfg_write, cfg_index and
// cfg_data, by the user only while the block is idle, which it does not check.
module three_band_audio_level_meter #(
	parameter int MAX_BLOCK = 4096
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  tbalm_pkg::in_beat_t                  in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output tbalm_pkg::out_beat_t                 out_data,
	input  logic                                 cfg_write,
	input  logic [tbalm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tbalm_pkg::CFG_DATA_W-1:0]     cfg_data
);

	tbalm_pkg::cfg_regs_t  cfg_q;
	tbalm_pkg::block_rec_t push_rec, head_rec;
	logic push_valid, head_valid, pop;

	// Configuration registers; writes to unused indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_coef <= tbalm_pkg::COEF_W'(1526);
			cfg_q.mid_coef <= tbalm_pkg::COEF_W'(15093);
			cfg_q.atk_fact <= tbalm_pkg::FACT_ONE;
			cfg_q.rel_fact <= tbalm_pkg::FACT_ONE;
			cfg_q.gain     <= tbalm_pkg::GAIN_W'(256);
		end else if (cfg_write) begin
			unique case (tbalm_pkg::cfg_index_t'(cfg_index))
				tbalm_pkg::CFG_LOW_COEF: cfg_q.low_coef <= cfg_data[tbalm_pkg::COEF_W-1:0];
				tbalm_pkg::CFG_MID_COEF: cfg_q.mid_coef <= cfg_data[tbalm_pkg::COEF_W-1:0];
				tbalm_pkg::CFG_ATTACK:   cfg_q.atk_fact <= cfg_data;
				tbalm_pkg::CFG_RELEASE:  cfg_q.rel_fact <= cfg_data;
				tbalm_pkg::CFG_GAIN:     cfg_q.gain     <= cfg_data[tbalm_pkg::GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	tbalm_front #(.MAX_BLOCK(MAX_BLOCK)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.cfg        (cfg_q),
		.pop        (pop),
		.push_valid (push_valid),
		.push_rec   (push_rec)
	);

	tbalm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_rec   (push_rec),
		.pop        (pop),
		.head_valid (head_valid),
		.head_rec   (head_rec)
	);

	tbalm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head_rec   (head_rec),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule

### rtl/tbalm_checker.sv
// Port-level checker for the level meter and its bind to the top level.
module tbalm_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input tbalm_pkg::in_beat_t  in_data,
	input logic                 out_valid,
	input logic                 out_stall,
	input tbalm_pkg::out_beat_t out_data
);

	logic [2:0] pend_q;

	// Blocks whose last beat went in and whose result beat has not come out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 3'(in_valid && !in_stall && in_data.last_of_block)
				- 3'(out_valid && !out_stall);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_data))
		else $error("result payload changed while stalled");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |-> pend_q != 3'd0)
		else $error("result beat without a finished block");

	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == 3'd0 |-> !in_stall)
		else $error("input stalled with no block outstanding");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'(tbalm_pkg::Q_DEPTH + 2))
		else $error("too many blocks outstanding");

endmodule

bind three_band_audio_level_meter tbalm_checker u_tbalm_checker (.*);

### tb/sv/three_band_audio_level_meter_tb.sv
// Testbench for the three-band audio level meter: directed table, random blocks, predictor check.
module three_band_audio_level_meter_tb;

	localparam int      CLK_HALF   = 6;
	localparam int      DRAIN_WAIT = 450;    // quiet time after the last expected result, so the back end is idle
	localparam int      LONG_HOLD  = 3000;   // long receiver hold-off, in cycles
	localparam longint  RUN_LIMIT  = 64'd3_000_000 * 12;
	localparam longint unsigned SQ_CAP = (64'd1 << 60) - 1;

	logic                                  clk = 1'b0;
	logic                                  arst_n = 1'b0;
	logic                                  in_valid = 1'b0;
	logic                                  in_stall;
	tbalm_pkg::in_beat_t                   in_data = '0;
	logic                                  out_valid;
	logic                                  out_stall = 1'b0;
	tbalm_pkg::out_beat_t                  out_data;
	logic                                  cfg_write = 1'b0;
	logic [tbalm_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
	logic [tbalm_pkg::CFG_DATA_W-1:0]      cfg_data = '0;

	three_band_audio_level_meter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Shadow copy of the register file and of the meter's running state.
	longint unsigned m_low_coef, m_mid_coef, m_attack, m_release, m_gain;
	longint          m_low_filt, m_mid_filt, m_low_saved, m_mid_saved;
	bit              m_open;
	longint unsigned m_sums [tbalm_pkg::N_BANDS];
	longint unsigned m_peak;
	int              m_count;
	longint          m_env [tbalm_pkg::N_BANDS];

	tbalm_pkg::out_beat_t level_queue [$];   // expected result beats, oldest first
	int        fail_count = 0;
	int        sender_idle = 1;   // 0: the sender offers back to back
	int        receiver_idle = 1; // 0: the receiver never stalls
	bit        hold_request = 1'b0;

	function automatic longint unsigned magnitude_of(longint v);
		return (v < 0) ? longint'(-v) : v;
	endfunction

	// Integer square root, rounded down, one result bit per pass.
	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned r;
		longint unsigned bitpos;
		r = 0;
		bitpos = 64'd1 << 62;
		while (bitpos > v)
			bitpos >>= 2;
		while (bitpos != 0) begin
			if (v >= r + bitpos) begin
				v -= r + bitpos;
				r = (r >> 1) + bitpos;
			end else begin
				r >>= 1;
			end
			bitpos >>= 2;
		end
		return r;
	endfunction

	function automatic logic [tbalm_pkg::LEVEL_W-1:0] scaled_level(longint unsigned v);
		longint unsigned p;
		p = (v * m_gain) >> tbalm_pkg::OUT_SHIFT;
		return (p > 65535) ? 16'hFFFF : p[15:0];
	endfunction

	function automatic void accumulate_square(int band, longint v);
		longint unsigned m;
		longint unsigned sq;
		longint unsigned t;
		m = magnitude_of(v);
		sq = (m >= (64'd1 << 30)) ? SQ_CAP : m * m;
		t = m_sums[band] + sq;
		m_sums[band] = (t > SQ_CAP) ? SQ_CAP : t;
	endfunction

	function automatic void meter_reset();
		m_low_coef = 1526;
		m_mid_coef = 15093;
		m_attack = 65536;
		m_release = 65536;
		m_gain = 256;
		m_low_filt = 0;
		m_mid_filt = 0;
		m_low_saved = 0;
		m_mid_saved = 0;
		m_open = 1'b0;
		m_peak = 0;
		m_count = 0;
		for (int i = 0; i < tbalm_pkg::N_BANDS; i++) begin
			m_sums[i] = 0;
			m_env[i] = 0;
		end
	endfunction

	// Advances the shadow meter by one sample; gives a result on the last beat of a block.
	function automatic bit meter_step(tbalm_pkg::in_beat_t b, output tbalm_pkg::out_beat_t r);
		longint          s;
		longint          band [tbalm_pkg::N_BANDS];
		longint          target;
		longint unsigned fact;
		s = b.sample;
		r = '0;
		if (!m_open) begin
			m_low_saved = m_low_filt;
			m_mid_saved = m_mid_filt;
			m_open = 1'b1;
		end
		m_low_filt += ((s - m_low_filt) * longint'(m_low_coef)) >>> 16;
		m_mid_filt += ((s - m_mid_filt) * longint'(m_mid_coef)) >>> 16;
		band[0] = s;
		band[1] = m_low_filt;
		band[2] = m_mid_filt - m_low_filt;
		band[3] = s - m_mid_filt;
		for (int i = 0; i < tbalm_pkg::N_BANDS; i++)
			accumulate_square(i, band[i]);
		if (magnitude_of(s) > m_peak)
			m_peak = magnitude_of(s);
		if (m_count < 4096)
			m_count++;
		if (!b.last_of_block)
			return 1'b0;
		if (b.muted) begin
			m_low_filt = m_low_saved;
			m_mid_filt = m_mid_saved;
		end else begin
			for (int i = 0; i < tbalm_pkg::N_BANDS; i++) begin
				target = root_floor(m_sums[i] / longint'(m_count));
				fact = (target > m_env[i]) ? m_attack : m_release;
				if (fact > 65536)
					fact = 65536;
				m_env[i] += ((target - m_env[i]) * longint'(fact)) >>> 16;
			end
			r.level      = scaled_level(m_env[0]);
			r.peak       = scaled_level(m_peak);
			r.low_level  = scaled_level(m_env[1]);
			r.mid_level  = scaled_level(m_env[2]);
			r.high_level = scaled_level(m_env[3]);
		end
		for (int i = 0; i < tbalm_pkg::N_BANDS; i++)
			m_sums[i] = 0;
		m_peak = 0;
		m_count = 0;
		m_open = 1'b0;
		return 1'b1;
	endfunction

	// Register write; only called while nothing is in flight.
	task automatic write_register(tbalm_pkg::cfg_index_t idx, longint unsigned value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[tbalm_pkg::CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			tbalm_pkg::CFG_LOW_COEF: m_low_coef = value & 16'hFFFF;
			tbalm_pkg::CFG_MID_COEF: m_mid_coef = value & 16'hFFFF;
			tbalm_pkg::CFG_ATTACK:   m_attack   = value & 17'h1FFFF;
			tbalm_pkg::CFG_RELEASE:  m_release  = value & 17'h1FFFF;
			tbalm_pkg::CFG_GAIN:     m_gain     = value & 16'hFFFF;
			default: ;
		endcase
	endtask

	task automatic write_all(longint unsigned lo, longint unsigned mi, longint unsigned atk,
			longint unsigned rel, longint unsigned gn);
		write_register(tbalm_pkg::CFG_LOW_COEF, lo);
		write_register(tbalm_pkg::CFG_MID_COEF, mi);
		write_register(tbalm_pkg::CFG_ATTACK, atk);
		write_register(tbalm_pkg::CFG_RELEASE, rel);
		write_register(tbalm_pkg::CFG_GAIN, gn);
	endtask

	// Offers one sample beat and returns once it has been taken. The valid line is only
	// dropped when a gap is drawn, so back-to-back beats never see two updates in one step.
	// A typed-in expectation, when given, replaces the predicted one in the queue.
	task automatic send_sample(tbalm_pkg::in_beat_t b, bit typed = 1'b0,
			tbalm_pkg::out_beat_t typed_val = '0);
		int                   gap;
		tbalm_pkg::out_beat_t predicted;
		gap = sender_idle ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= b;
		do @(posedge clk); while (in_stall);
		if (meter_step(b, predicted))
			level_queue.push_back(typed ? typed_val : predicted);
	endtask

	// Drops valid right after the last accepted beat, waits for every expected result,
	// then long enough that the back end is quiet.
	task automatic drain();
		in_valid <= 1'b0;
		while (level_queue.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// Random sample: a random word is shifted down by a drawn amount so that quiet signals, where the
	// envelopes and gain do not saturate, are as common as full-scale ones.
	function automatic logic signed [tbalm_pkg::SAMPLE_BITS-1:0] random_sample();
		logic signed [tbalm_pkg::SAMPLE_BITS-1:0] v;
		int                                       sh;
		v = tbalm_pkg::SAMPLE_BITS'($urandom);
		sh = $urandom_range(0, 23);
		return v >>> sh;
	endfunction

	typedef struct {
		tbalm_pkg::in_beat_t  beat;
		bit                   typed;
		tbalm_pkg::out_beat_t result;
	} stim_row_t;

	localparam tbalm_pkg::out_beat_t ALL_ZERO = '0;

	// Directed rows at reset settings. Single-sample zero blocks and muted blocks have
	// obvious results; the others go through the predictor.
	stim_row_t directed [] = '{
		'{'{24'sd0, 1'b1, 1'b0}, 1'b1, ALL_ZERO},
		'{'{24'sh7FFFFF, 1'b1, 1'b0}, 1'b0, ALL_ZERO},
		'{'{-24'sd8388608, 1'b1, 1'b0}, 1'b0, ALL_ZERO},
		'{'{24'sh7FFFFF, 1'b0, 1'b0}, 1'b0, ALL_ZERO},
		'{'{-24'sd8388608, 1'b0, 1'b1}, 1'b0, ALL_ZERO},
		'{'{24'sh555555, 1'b0, 1'b0}, 1'b0, ALL_ZERO},
		'{'{24'shAAAAAA, 1'b1, 1'b1}, 1'b1, ALL_ZERO},
		'{'{24'sd1, 1'b0, 1'b0}, 1'b0, ALL_ZERO},
		'{'{-24'sd1, 1'b0, 1'b0}, 1'b0, ALL_ZERO},
		'{'{24'sd4096, 1'b0, 1'b0}, 1'b0, ALL_ZERO},
		'{'{-24'sd300000, 1'b1, 1'b0}, 1'b0, ALL_ZERO},
		'{'{24'sh123456, 1'b0, 1'b0}, 1'b0, ALL_ZERO},
		'{'{24'shEDCBA9, 1'b0, 1'b0}, 1'b0, ALL_ZERO},
		'{'{24'sh0F0F0F, 1'b1, 1'b0}, 1'b0, ALL_ZERO},
		'{'{24'sd1000, 1'b0, 1'b0}, 1'b0, ALL_ZERO},
		'{'{24'sd2000, 1'b0, 1'b0}, 1'b0, ALL_ZERO},
		'{'{24'sd3000, 1'b1, 1'b1}, 1'b1, ALL_ZERO},
		'{'{24'sd7, 1'b1, 1'b0}, 1'b0, ALL_ZERO}
	};

	// Receiver: one drawn stall per result beat, or the long hold when it is asked for.
	initial begin : receiver
		int                   hold;
		tbalm_pkg::out_beat_t want;
		forever begin
			if (hold_request) begin
				hold = LONG_HOLD;
				hold_request = 1'b0;
			end else begin
				hold = receiver_idle ? $urandom_range(0, 19) : 0;
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!(out_valid && !out_stall));
			if (level_queue.size() == 0) begin
				$error("result beat with no expectation waiting: %h", out_data);
				fail_count++;
			end else begin
				want = level_queue.pop_front();
				if (out_data.level !== want.level) begin
					$error("level: expected %0d, got %0d", want.level, out_data.level);
					fail_count++;
				end
				if (out_data.peak !== want.peak) begin
					$error("peak: expected %0d, got %0d", want.peak, out_data.peak);
					fail_count++;
				end
				if (out_data.low_level !== want.low_level) begin
					$error("low_level: expected %0d, got %0d", want.low_level,
						out_data.low_level);
					fail_count++;
				end
				if (out_data.mid_level !== want.mid_level) begin
					$error("mid_level: expected %0d, got %0d", want.mid_level,
						out_data.mid_level);
					fail_count++;
				end
				if (out_data.high_level !== want.high_level) begin
					$error("high_level: expected %0d, got %0d", want.high_level,
						out_data.high_level);
					fail_count++;
				end
			end
		end
	end

	// Stimulus: reset, the directed table, then random phases under a spread of
	// register settings, the reset values and the extremes first.
	initial begin : stimulus
		tbalm_pkg::in_beat_t b;
		int       sent;
		int       blen;
		static longint unsigned setting [8][5] = '{
			'{1526, 15093, 65536, 65536, 256},
			'{0, 0, 0, 0, 65535},
			'{65535, 65535, 131071, 131071, 0},
			'{65535, 0, 65536, 0, 1},
			'{0, 65535, 1, 65535, 128},
			'{3000, 30000, 8000, 2000, 512},
			'{500, 20000, 40000, 600, 40},
			'{1526, 15093, 20000, 90000, 300}
		};
		meter_reset();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Full-scale samples of both signs come early, while the envelopes still start
		// from zero and the attack jumps straight to the target.
		foreach (directed[i])
			send_sample(directed[i].beat, directed[i].typed, directed[i].result);
		drain();

		for (int ph = 0; ph < 11; ph++) begin
			if (ph < 8)
				write_all(setting[ph][0], setting[ph][1], setting[ph][2], setting[ph][3],
					setting[ph][4]);
			else
				write_all($urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 65536), $urandom_range(0, 65536),
					$urandom_range(0, 65535));
			// Some phases run with no idling on one or both sides.
			sender_idle   = (ph % 3 != 1);
			receiver_idle = (ph % 4 != 2);
			// One phase of single-sample blocks behind a long receiver hold fills the
			// result queue so that the input stalls.
			if (ph == 5) begin
				sender_idle = 0;
				hold_request = 1'b1;
			end
			sent = 0;
			while (sent < 45) begin
				blen = (ph == 5) ? 1 : (($urandom_range(0, 9) == 0) ?
					$urandom_range(20, 80) : $urandom_range(1, 8));
				for (int k = 0; k < blen; k++) begin
					b.sample = random_sample();
					b.last_of_block = (k == blen - 1);
					b.muted = ($urandom_range(0, 5) == 0);
					send_sample(b);
				end
				sent += blen;
			end
			drain();
		end

		if (fail_count == 0)
			$display("three_band_audio_level_meter: match");
		else
			$display("three_band_audio_level_meter: mismatch");
		$finish;
	end

	// Watchdog: ends the run if results stop coming.
	initial begin : watchdog
		#RUN_LIMIT;
		$display("three_band_audio_level_meter: mismatch");
		$finish;
	end

endmodule

### three_band_audio_level_meter.f
rtl/tbalm_pkg.sv
rtl/tbalm_front.sv
rtl/tbalm_queue.sv
rtl/tbalm_back.sv
rtl/three_band_audio_level_meter.sv
rtl/tbalm_checker.sv
tb/sv/three_band_audio_level_meter_tb.sv
